// ===== src/tcpf_pkg.sv =====
// Package: types, codes and sizes shared by the three-class priority queue.
package tcpf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ITEM_WIDTH  = 32;

	localparam int DATA_W  = 32;
	localparam int STORE_W = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W   = 2;
	localparam int ADDR_W  = CLS_W + PTR_W;
	localparam int NUM_CLASSES = 3;

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_DEQUEUED = 3'd1,
		ST_INVALID  = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam logic [2:0] PRIO_URGENT    = 3'd1;
	localparam logic [2:0] PRIO_IMPORTANT = 3'd2;
	localparam logic [2:0] PRIO_STANDARD  = 3'd3;

	localparam logic [CLS_W-1:0] CLS_URGENT    = 2'd0;
	localparam logic [CLS_W-1:0] CLS_IMPORTANT = 2'd1;
	localparam logic [CLS_W-1:0] CLS_STANDARD  = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [31:0] item_data;
		logic [2:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [31:0] out_data;
		logic [1:0]  out_class;
		status_t     status;
	} rsp_t;

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		status_t          status;
		logic             take_rd;
	} meta_t;

	function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

endpackage

// ===== src/three_class_priority_fifo_unit.sv =====
// Top level: three-class strict-priority queue over one shared entry memory.
//
// Usage: each request on req (valid/ready) is an enqueue or a dequeue.
// An enqueue with class code 1, 2 or 3 stores its word in the urgent,
// important or standard FIFO; other codes answer "invalid", and a push to
// a full FIFO is dropped and answers "full". A dequeue returns the head of
// the highest-priority non-empty FIFO, or "all empty".
// Every request yields exactly one response on rsp (valid/ready), in order.
// Each accepted request passes the registered read of the entry memory and
// then the response register before its response is valid.
// Throughput: one request per cycle while responses are taken; the single
// read/write port of the entry memory carries one access per request.
// Reset clears all pointers and fill counts (all FIFOs empty) and the
// pipeline; the entry memory is not cleared, no empty entry is ever read.
// When the receiver stalls, the response register and the stage behind it
// hold, and req_ready drops once both are occupied.
module three_class_priority_fifo_unit
	import tcpf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [STORE_W-1:0] store_mem [2**ADDR_W];

	logic [PTR_W-1:0] rd_ptr_q [NUM_CLASSES];
	logic [PTR_W-1:0] wr_ptr_q [NUM_CLASSES];
	logic [CNT_W-1:0] count_q  [NUM_CLASSES];

	logic               valid_s1;
	meta_t              meta_s1;
	logic [STORE_W-1:0] rd_data_s1;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic             accept;
	logic             out_free;
	logic             advance_s1;
	logic             enq_ok;
	logic             deq_ok;
	logic [CLS_W-1:0] enq_cls;
	logic             enq_code_ok;
	logic [CLS_W-1:0] deq_cls;
	logic             any_full;
	meta_t            meta_d;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign advance_s1 = valid_s1 && out_free;
	assign req_ready  = !valid_s1 || out_free;
	assign accept     = req_valid && req_ready;

	always_comb begin
		case (req.priority_req)
			PRIO_URGENT: begin
				enq_cls     = CLS_URGENT;
				enq_code_ok = 1'b1;
			end
			PRIO_IMPORTANT: begin
				enq_cls     = CLS_IMPORTANT;
				enq_code_ok = 1'b1;
			end
			PRIO_STANDARD: begin
				enq_cls     = CLS_STANDARD;
				enq_code_ok = 1'b1;
			end
			default: begin
				enq_cls     = CLS_URGENT;
				enq_code_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		deq_cls = CLS_URGENT;
		deq_ok  = 1'b1;
		if (count_q[0] != '0) begin
			deq_cls = CLS_URGENT;
		end else if (count_q[1] != '0) begin
			deq_cls = CLS_IMPORTANT;
		end else if (count_q[2] != '0) begin
			deq_cls = CLS_STANDARD;
		end else begin
			deq_ok = 1'b0;
		end
	end

	assign any_full = enq_code_ok && (count_q[enq_cls] == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		meta_d  = '{cls: CLS_URGENT, status: ST_EMPTY, take_rd: 1'b0};
		enq_ok  = 1'b0;
		if (req.cmd == CMD_ENQUEUE) begin
			if (!enq_code_ok) begin
				meta_d.status = ST_INVALID;
			end else if (any_full) begin
				meta_d.cls    = enq_cls;
				meta_d.status = ST_FULL;
			end else begin
				meta_d.cls    = enq_cls;
				meta_d.status = ST_ENQUEUED;
				enq_ok        = 1'b1;
			end
		end else if (deq_ok) begin
			meta_d.cls     = deq_cls;
			meta_d.status  = ST_DEQUEUED;
			meta_d.take_rd = 1'b1;
		end
	end

	assign wr_addr = {enq_cls, wr_ptr_q[enq_cls]};
	assign rd_addr = {deq_cls, rd_ptr_q[deq_cls]};

	always_ff @(posedge clk) begin
		if (accept && enq_ok) begin
			store_mem[wr_addr] <= req.item_data[STORE_W-1:0];
		end
		if (accept && meta_d.take_rd) begin
			rd_data_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else if (accept) begin
			if (enq_ok) begin
				wr_ptr_q[enq_cls] <= ptr_advance(wr_ptr_q[enq_cls]);
				count_q[enq_cls]  <= count_q[enq_cls] + CNT_W'(1);
			end else if (meta_d.take_rd) begin
				rd_ptr_q[deq_cls] <= ptr_advance(rd_ptr_q[deq_cls]);
				count_q[deq_cls]  <= count_q[deq_cls] - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rsp_q.out_data  <= meta_s1.take_rd ? DATA_W'(rd_data_s1) : '0;
			rsp_q.out_class <= meta_s1.cls;
			rsp_q.status    <= meta_s1.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/tcpf_checker.sv =====
// Checker for the three-class priority queue: predicts each response and compares it.
`timescale 1ns / 100ps

module tcpf_checker
	import tcpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	logic [DATA_W-1:0] lane_mem [NUM_CLASSES][QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_ptr [NUM_CLASSES];
	logic [PTR_W-1:0]  tail_ptr [NUM_CLASSES];
	int                lane_fill [NUM_CLASSES];
	rsp_t              expected_q [$];
	int unsigned       error_total;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
	endfunction

	function automatic rsp_t predict_response(input req_t r);
		rsp_t res;
		int   lane;
		res = '0;
		lane = -1;
		if (r.cmd == CMD_ENQUEUE) begin
			case (r.priority_req)
				PRIO_URGENT: begin
					lane = int'(CLS_URGENT);
				end
				PRIO_IMPORTANT: begin
					lane = int'(CLS_IMPORTANT);
				end
				PRIO_STANDARD: begin
					lane = int'(CLS_STANDARD);
				end
				default: begin
					lane = -1;
				end
			endcase
			if (lane < 0) begin
				res.status = ST_INVALID;
			end else begin
				res.out_class = 2'(lane);
				if (lane_fill[lane] >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					lane_mem[lane][tail_ptr[lane]] = DATA_W'(r.item_data[STORE_W-1:0]);
					tail_ptr[lane] = wrap_next(tail_ptr[lane]);
					lane_fill[lane]++;
					res.status = ST_ENQUEUED;
				end
			end
		end else begin
			// lowest index wins: urgent before important before standard
			for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
				if (lane_fill[c] != 0) begin
					lane = c;
				end
			end
			if (lane < 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_data = lane_mem[lane][head_ptr[lane]];
				res.out_class = 2'(lane);
				res.status = ST_DEQUEUED;
				head_ptr[lane] = wrap_next(head_ptr[lane]);
				lane_fill[lane]--;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_ptr[c] = '0;
				tail_ptr[c] = '0;
				lane_fill[c] = 0;
			end
			expected_q.delete();
			error_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_q.push_back(predict_response(req));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected response data=%h class=%0d status=%0d",
						$time, rsp.out_data, rsp.out_class, rsp.status);
					error_total++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.out_data !== want.out_data) begin
						$display("%0t: out_data expected %h got %h",
							$time, want.out_data, rsp.out_data);
						error_total++;
					end
					if (rsp.out_class !== want.out_class) begin
						$display("%0t: out_class expected %0d got %0d",
							$time, want.out_class, rsp.out_class);
						error_total++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, rsp.status);
						error_total++;
					end
				end
			end
			mismatches <= error_total;
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the priority queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import tcpf_pkg::*;

	localparam int DIRECTED_REQUESTS = 25;
	localparam int RANDOM_REQUESTS   = 1300;
	localparam int HOLD_START        = 400;
	localparam int HOLD_CYCLES       = 200;
	localparam int DRAIN_CYCLES      = 10;
	localparam int CYCLE_LIMIT       = 200000;

	localparam logic [2:0] PRIO_NONE    = 3'd0;
	localparam logic [2:0] PRIO_TOP_BAD = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        rsp_ready = 1'b0;
	req_t        req = '0;
	logic        req_ready;
	logic        rsp_valid;
	rsp_t        rsp;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned sent = 0;
	logic        hold_wanted = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	three_class_priority_fifo_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	tcpf_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic req_t make_req(input cmd_t c, input logic [2:0] prio,
		input logic [31:0] data);
		req_t r;
		r.cmd = c;
		r.item_data = data;
		r.priority_req = prio;
		return r;
	endfunction

	task automatic send(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic random_episode();
		int          kind;
		int          len;
		int          enq_pct;
		logic [2:0]  home;
		kind = $urandom_range(0, 3);
		len = $urandom_range(10, 60);
		home = 3'($urandom_range(1, 3));
		case (kind)
			0: begin
				enq_pct = 85;
			end
			1: begin
				enq_pct = 20;
			end
			default: begin
				enq_pct = 50;
			end
		endcase
		repeat (len) begin
			logic [2:0] prio;
			if ($urandom_range(99) < enq_pct) begin
				if (kind == 3) begin
					prio = 3'($urandom_range(0, 7));
				end else if (kind == 0 && $urandom_range(3) != 0) begin
					prio = home;
				end else begin
					prio = 3'($urandom_range(1, 3));
				end
				send(make_req(CMD_ENQUEUE, prio, $urandom));
			end else begin
				send(make_req(CMD_DEQUEUE, 3'($urandom_range(0, 7)), $urandom));
			end
		end
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send(make_req(CMD_DEQUEUE, PRIO_URGENT, 32'h0));
		send(make_req(CMD_ENQUEUE, PRIO_NONE, 32'hffff_ffff));
		send(make_req(CMD_ENQUEUE, PRIO_TOP_BAD, 32'h1234_5678));
		send(make_req(CMD_ENQUEUE, PRIO_STANDARD, 32'h0));
		send(make_req(CMD_ENQUEUE, PRIO_IMPORTANT, 32'hffff_ffff));
		repeat (QUEUE_DEPTH) send(make_req(CMD_ENQUEUE, PRIO_URGENT, $urandom));
		send(make_req(CMD_ENQUEUE, PRIO_URGENT, 32'hffff_ffff));
		repeat (3) send(make_req(CMD_DEQUEUE, PRIO_STANDARD, $urandom));
		while (sent < DIRECTED_REQUESTS + RANDOM_REQUESTS) begin
			if (sent >= HOLD_START) begin
				hold_wanted = 1'b1;
			end
			random_episode();
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[three_class_priority_fifo_unit] OK");
		end else begin
			$display("[three_class_priority_fifo_unit] ERROR");
		end
		$finish;
	end

	initial begin : receiver
		int mode;
		int span;
		bit held;
		held = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 200);
			repeat (span) begin
				if (hold_wanted && !held) begin
					rsp_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					held = 1'b1;
				end
				case (mode)
					0: begin
						rsp_ready <= 1'b1;
					end
					1: begin
						rsp_ready <= ($urandom_range(1) == 1);
					end
					default: begin
						rsp_ready <= ($urandom_range(3) == 0);
					end
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[three_class_priority_fifo_unit] ERROR");
			$finish;
		end
	end

endmodule
